@@ src/assert_macros.svh @@
// Assertion helpers for the blend unit checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define AWB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define AWB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/awb_pkg.sv @@
package awb_pkg;

  localparam int NCH = 4;
  localparam int PIX_W = 8;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] MAX_NCH = 3'd4;
  localparam logic [CNT_W-1:0] MIN_ROM_NCH = 3'd3;
  localparam logic [63:0] LOG10_2_Q32 = 64'd1292913986;
  localparam int ALPHA_FULL = 255;
  localparam int ALPHA_ROUND = 127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADAPTIVE_MODE = 3'd0,
    REG_BLEND_AMOUNT  = 3'd1,
    REG_BLEND_MIN     = 3'd2,
    REG_BLEND_MAX     = 3'd3,
    REG_CHANNEL_COUNT = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SRC_AMOUNT,
    SRC_MIN,
    SRC_ROM
  } blend_src_t;

  typedef struct packed {
    logic [NCH-1:0][PIX_W-1:0] bg;
    logic [NCH-1:0][PIX_W-1:0] fg;
  } pix_t;

  typedef struct packed {
    blend_src_t       src;
    logic [CNT_W-1:0] nch;
  } cls_t;

  // log2(n), 32 fraction bits, squaring method with truncated squares
  function automatic logic [63:0] log2_q32(input logic [31:0] n);
    logic [5:0]  p;
    logic [63:0] m;
    logic [63:0] r;
    p = '0;
    for (int j = 0; j < 31; j++) begin
      if ((n >> (p + 6'd1)) != 32'd0) begin
        p = p + 6'd1;
      end
    end
    m = 64'(n) << (6'd31 - p);
    r = 64'(p) << 32;
    for (int k = 31; k >= 0; k--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  // log10(1 + 9i/255) in Q1.fb, rounded, ceiling at one
  function automatic logic [63:0] rom_entry(input int unsigned fb, input int unsigned idx);
    logic [63:0] base;
    logic [63:0] d;
    logic [63:0] prod;
    logic [63:0] v;
    logic [63:0] one;
    base = log2_q32(32'd255);
    d    = (log2_q32(32'(255 + 9 * idx)) - base) >> 2;
    prod = d * LOG10_2_Q32;
    v    = (prod + (64'd1 << (61 - fb))) >> (62 - fb);
    one  = 64'd1 << fb;
    return (v > one) ? one : v;
  endfunction

endpackage

@@ src/awb_front.sv @@
module awb_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  awb_pkg::pix_t                   pix_in,
  input  logic                            adaptive_mode,
  input  logic [awb_pkg::CNT_W-1:0]       channel_count,
  input  logic                            q_full,
  output logic                            q_push,
  output awb_pkg::pix_t                   q_pix,
  output awb_pkg::cls_t                   q_cls,
  output logic [FRAC_BITS:0]              q_rom
);
  import awb_pkg::*;

  localparam int BW = FRAC_BITS + 1;

  logic [BW-1:0] rom_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_rom
    assign rom_tab[g] = BW'(rom_entry(FRAC_BITS, g));
  end

  logic          s1_valid;
  pix_t          s1_pix;
  cls_t          s1_cls;
  logic [7:0]    s1_bright;
  logic          s2_valid;
  pix_t          s2_pix;
  cls_t          s2_cls;
  logic [BW-1:0] s2_rom;

  logic             take;
  logic             s1_load;
  logic             s2_load;
  logic [CNT_W-1:0] nch_eff;
  cls_t             cls_in;
  logic [10:0]      bright_sum;

  assign q_push  = s2_valid && !q_full;
  assign s2_load = !s2_valid || q_push;
  assign s1_load = !s1_valid || s2_load;
  assign busy    = s1_valid && !s2_load;
  assign take    = start && !busy;

  always_comb begin
    nch_eff = (channel_count > MAX_NCH) ? MAX_NCH : channel_count;
    cls_in.nch = nch_eff;
    if (!adaptive_mode) begin
      cls_in.src = SRC_AMOUNT;
    end else if (nch_eff >= MIN_ROM_NCH) begin
      cls_in.src = SRC_ROM;
    end else begin
      cls_in.src = SRC_MIN;
    end
    // (3r + 4g + b) >> 3
    bright_sum = 11'(pix_in.bg[2]) + 11'(pix_in.bg[2]) + 11'(pix_in.bg[2])
               + (11'(pix_in.bg[1]) << 2) + 11'(pix_in.bg[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= take;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pix    <= pix_in;
      s1_cls    <= cls_in;
      s1_bright <= bright_sum[10:3];
    end
    if (s2_load) begin
      s2_pix <= s1_pix;
      s2_cls <= s1_cls;
      s2_rom <= rom_tab[s1_bright];
    end
  end

  assign q_pix = s2_pix;
  assign q_cls = s2_cls;
  assign q_rom = s2_rom;

endmodule

@@ src/awb_queue.sv @@
module awb_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic [1:0]        count_next;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ src/awb_back.sv @@
module awb_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_empty,
  output logic                                          q_pop,
  input  awb_pkg::pix_t                                 q_pix,
  input  awb_pkg::cls_t                                 q_cls,
  input  logic [FRAC_BITS:0]                            q_rom,
  input  logic [FRAC_BITS:0]                            blend_amount,
  input  logic [FRAC_BITS:0]                            blend_min,
  input  logic [FRAC_BITS:0]                            blend_max,
  output logic                                          done,
  output logic [awb_pkg::NCH-1:0][awb_pkg::PIX_W-1:0]   out_pix
);
  import awb_pkg::*;

  localparam int BW = FRAC_BITS + 1;
  localparam int XW = BW + 8;
  localparam int RW = XW - 7;
  localparam int YW = FRAC_BITS + 11;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << XW) / 64'd255);
  localparam logic [2*BW-1:0] HALF = (2*BW)'(1) << (FRAC_BITS - 1);

  // per-stage valid: B1..B5
  logic [4:0] v;

  pix_t          p1, p2, p3, p4, p5;
  logic [2:0]    n1, n2, n3, n4, n5;
  blend_src_t    src1;
  logic          neg1;
  logic [2*BW-1:0] prod1;
  logic [BW-1:0] blend2;
  logic [XW-1:0] x3;
  logic [XW-1:0] x4;
  logic [BW-1:0] q4;
  logic [BW-1:0] op5;

  logic [BW-1:0]      diff;
  logic               neg;
  logic [2*BW-1:0]    rnd_sum;
  logic [BW-1:0]      rnd;
  logic [BW-1:0]      blend_rom;
  logic [BW-1:0]      blend_sel;
  logic [XW+RW-1:0]   recip_prod;
  logic [XW-1:0]      q255;
  logic [XW-1:0]      rem;
  logic [BW-1:0]      op_next;
  logic signed [8:0]  dif [NCH];
  logic signed [YW-1:0] y_s [NCH];
  logic [NCH-1:0][PIX_W-1:0] out_next;

  assign q_pop = !q_empty;

  always_comb begin
    if (blend_max >= blend_min) begin
      diff = blend_max - blend_min;
      neg  = 1'b0;
    end else begin
      diff = blend_min - blend_max;
      neg  = 1'b1;
    end

    rnd_sum   = prod1 + HALF;
    rnd       = rnd_sum[FRAC_BITS +: BW];
    blend_rom = neg1 ? (blend_min - rnd) : (blend_min + rnd);
    unique case (src1)
      SRC_AMOUNT: blend_sel = blend_amount;
      SRC_MIN:    blend_sel = blend_min;
      SRC_ROM:    blend_sel = blend_rom;
      default:    blend_sel = blend_min;
    endcase

    // x / 255 by reciprocal, q is exact or one low
    recip_prod = (XW+RW)'(x3) * (XW+RW)'(RECIP);
    q255       = (XW'(q4) << 8) - XW'(q4);
    rem        = x4 - q255;
    op_next    = (rem >= XW'(ALPHA_FULL)) ? (q4 + BW'(1)) : q4;

    // bg*(1-op) + fg*op = (bg << F) + (fg - bg)*op
    for (int c = 0; c < NCH; c++) begin
      dif[c] = $signed({1'b0, p5.fg[c]}) - $signed({1'b0, p5.bg[c]});
      y_s[c] = $signed(YW'(p5.bg[c]) << FRAC_BITS)
             + YW'(dif[c]) * YW'($signed({1'b0, op5}));
      out_next[c] = (3'(c) < n5) ? PIX_W'(y_s[c][FRAC_BITS +: PIX_W]) : p5.bg[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[3:0], q_pop};
      done <= v[4];
    end
  end

  always_ff @(posedge clk) begin
    // B1: rom scaling product
    p1    <= q_pix;
    n1    <= q_cls.nch;
    src1  <= q_cls.src;
    neg1  <= neg;
    prod1 <= (2*BW)'(diff) * (2*BW)'(q_rom);
    // B2: blend select
    p2     <= p1;
    n2     <= n1;
    blend2 <= blend_sel;
    // B3: blend * alpha, rounded
    p3 <= p2;
    n3 <= n2;
    x3 <= XW'(blend2) * XW'(p2.fg[NCH-1]) + XW'(ALPHA_ROUND);
    // B4: reciprocal estimate
    p4 <= p3;
    n4 <= n3;
    x4 <= x3;
    q4 <= recip_prod[XW +: BW];
    // B5: quotient correction
    p5  <= p4;
    n5  <= n4;
    op5 <= op_next;
    // B6: channel mix
    out_pix <= out_next;
  end

endmodule

@@ src/adaptive_watermark_blend_unit.sv @@
// Adaptive watermark blend unit: alpha-blends one image pixel (b g r a) with
// one watermark pixel (b g r, alpha) per word.
//   Input: a word is taken at a rising edge with start high and busy low.
//     busy only rises if the internal queue backs up; in normal use it
//     stays low and a word can be taken on every clock.
//   Output: done is high for exactly one cycle with out_ch0..out_ch3 valid.
//     The receiver cannot stall; words come out in input order.
//   Path: the accepting edge loads front stage s1; the word then passes front
//     stage s2, 1 queue slot and the 6 back stages B1..B6 to done.
//   Throughput: 1 word per clock while busy is low; the back pipeline pops
//     the queue whenever it holds a word and never stalls.
//   Config: cfg_we/cfg_index/cfg_data write one register per edge; change
//     them only with no word in flight. Blend values above one saturate.
//   Reset (rst, synchronous): pipelines empty, registers at defaults
//     (standard mode, amount 3277, min 3277, max 32768, three channels).
module adaptive_watermark_blend_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  output logic                             done,
  input  logic                             cfg_we,
  input  logic [awb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [awb_pkg::CFG_W-1:0]        cfg_data,
  input  logic [7:0]                       bg_ch0,
  input  logic [7:0]                       bg_ch1,
  input  logic [7:0]                       bg_ch2,
  input  logic [7:0]                       bg_ch3,
  input  logic [7:0]                       wm_ch0,
  input  logic [7:0]                       wm_ch1,
  input  logic [7:0]                       wm_ch2,
  input  logic [7:0]                       wm_alpha,
  output logic [7:0]                       out_ch0,
  output logic [7:0]                       out_ch1,
  output logic [7:0]                       out_ch2,
  output logic [7:0]                       out_ch3
);
  import awb_pkg::*;

  localparam int BW = FRAC_BITS + 1;
  // wide enough for both a raw write and the value one
  localparam int CW = (BW > CFG_W) ? BW : CFG_W;
  localparam logic [CW-1:0] ONE_W = CW'(1) << FRAC_BITS;
  localparam logic [BW-1:0] ONE = BW'(1) << FRAC_BITS;
  // 0.05 and 0.5, rounded
  localparam logic [BW-1:0] RST_AMOUNT = BW'(((64'd1 << FRAC_BITS) * 5 + 50) / 100);
  localparam logic [BW-1:0] RST_MAX = BW'(64'd1 << (FRAC_BITS - 1));
  localparam int QW = $bits(pix_t) + $bits(cls_t) + BW;

  // config registers
  logic             adaptive_mode;
  logic [BW-1:0]    blend_amount;
  logic [BW-1:0]    blend_min;
  logic [BW-1:0]    blend_max;
  logic [CNT_W-1:0] channel_count;
  logic [BW-1:0]    cfg_sat;

  assign cfg_sat = (CW'(cfg_data) > ONE_W) ? ONE : BW'(CW'(cfg_data));

  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive_mode <= 1'b0;
      blend_amount  <= RST_AMOUNT;
      blend_min     <= RST_AMOUNT;
      blend_max     <= RST_MAX;
      channel_count <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ADAPTIVE_MODE: adaptive_mode <= cfg_data[0];
        REG_BLEND_AMOUNT:  blend_amount  <= cfg_sat;
        REG_BLEND_MIN:     blend_min     <= cfg_sat;
        REG_BLEND_MAX:     blend_max     <= cfg_sat;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CNT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // front -> queue -> back
  pix_t          pix_in;
  pix_t          f_pix;
  cls_t          f_cls;
  logic [BW-1:0] f_rom;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  logic [QW-1:0] q_rd;
  pix_t          b_pix;
  cls_t          b_cls;
  logic [BW-1:0] b_rom;
  logic [NCH-1:0][PIX_W-1:0] out_pix;

  assign pix_in.bg = {bg_ch3, bg_ch2, bg_ch1, bg_ch0};
  assign pix_in.fg = {wm_alpha, wm_ch2, wm_ch1, wm_ch0};

  awb_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pix_in       (pix_in),
    .adaptive_mode(adaptive_mode),
    .channel_count(channel_count),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_pix        (f_pix),
    .q_cls        (f_cls),
    .q_rom        (f_rom)
  );

  awb_queue #(
    .DATA_W(QW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_data({f_pix, f_cls, f_rom}),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_data(q_rd)
  );

  assign {b_pix, b_cls, b_rom} = q_rd;

  awb_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_pix       (b_pix),
    .q_cls       (b_cls),
    .q_rom       (b_rom),
    .blend_amount(blend_amount),
    .blend_min   (blend_min),
    .blend_max   (blend_max),
    .done        (done),
    .out_pix     (out_pix)
  );

  assign out_ch0 = out_pix[0];
  assign out_ch1 = out_pix[1];
  assign out_ch2 = out_pix[2];
  assign out_ch3 = out_pix[3];

endmodule

@@ src/awb_checker.sv @@
`include "assert_macros.svh"

module awb_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [7:0] bg_ch0,
  input logic [7:0] bg_ch3,
  input logic [7:0] wm_alpha,
  input logic [7:0] out_ch0,
  input logic [7:0] out_ch3
);

  // accepting edge to the edge that samples done
  localparam int LAT = 9;

  logic accept;
  assign accept = start && !busy && !rst;

  `AWB_ASSERT(a_word_out, clk, rst, accept |-> ##LAT done, "accepted word produced no result")
  `AWB_ASSERT(a_no_phantom, clk, rst, done |-> $past(accept, LAT), "result without an input word")
  `AWB_ASSERT(a_alpha_zero, clk, rst, (done && $past(accept && wm_alpha == 8'd0, LAT)) |-> (out_ch0 == $past(bg_ch0, LAT) && out_ch3 == $past(bg_ch3, LAT)), "zero alpha pixel altered")
  `AWB_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !done, "done right after reset")

endmodule

bind adaptive_watermark_blend_unit awb_checker u_awb_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .bg_ch0  (bg_ch0),
  .bg_ch3  (bg_ch3),
  .wm_alpha(wm_alpha),
  .out_ch0 (out_ch0),
  .out_ch3 (out_ch3)
);
